// ----- design/sfs_pkg.sv -----
package sfs_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_PLAY      = 3'd1;
    localparam logic [2:0] REQ_STOP      = 3'd2;
    localparam logic [2:0] REQ_GOTO_PLAY = 3'd3;
    localparam logic [2:0] REQ_GOTO_STOP = 3'd4;
    localparam logic [2:0] REQ_NEXT      = 3'd5;
    localparam logic [2:0] REQ_PREV      = 3'd6;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_FRAME_RATE  = 2'd1;
    localparam logic [1:0] REG_CLIP_LOADED = 2'd2;

    localparam int MAX_FRAMES = 256;
    localparam logic [8:0] FRAME_LIMIT = (MAX_FRAMES < 256) ? 9'(MAX_FRAMES) : 9'd256;

    localparam int MS_PER_SEC = 1000;

    // floor(d / 1000) = ((d >> 3) * RECIP_M) >> RECIP_SHIFT for d below 2^26
    localparam logic [23:0] RECIP_M     = 24'd8589935;
    localparam int          RECIP_SHIFT = 30;

    // 2^32 = WRAP_Q * 1000 + WRAP_R
    localparam logic [22:0] WRAP_Q = 23'd4294967;
    localparam logic [11:0] WRAP_R = 12'd296;

    typedef struct packed {
        logic [8:0] frame_count;
        logic [9:0] frame_rate;
        logic       clip_loaded;
    } sfs_cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] tick_ms;
        logic [7:0]  target_frame;
    } sfs_in_t;

    typedef struct packed {
        logic [7:0] current_frame;
        logic       playing;
        logic       cycle_done;
    } sfs_out_t;

    // Item in flight: request plus the precomputed time step
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  target_frame;
        logic [25:0] delta;   // tick_ms * frame_rate
        logic [16:0] dq;      // delta / 1000
        logic [9:0]  dr;      // delta % 1000
    } sfs_work_t;

endpackage

// ----- design/sfs_delta.sv -----
module sfs_delta import sfs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  sfs_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  sfs_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sfs_work_t out_work
);

    logic      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic      s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    sfs_in_t   s1_reg;
    sfs_work_t s2_reg, s3_reg, s4_reg;
    sfs_work_t s2_next, s3_next, s4_next;
    logic      s1_ready, s2_ready, s3_ready, s4_ready;
    logic [46:0] recip_prod;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid     : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;

    // Stage 1: scale the elapsed time by the frame rate
    always_comb
    begin
        s2_next              = '0;
        s2_next.req_type     = s1_reg.req_type;
        s2_next.target_frame = s1_reg.target_frame;
        s2_next.delta        = 26'(s1_reg.tick_ms) * 26'(cfg.frame_rate);
    end

    // Stage 2: quotient by 1000 through the reciprocal
    assign recip_prod = 47'(s2_reg.delta[25:3]) * 47'(RECIP_M);

    always_comb
    begin
        s3_next    = s2_reg;
        s3_next.dq = recip_prod[RECIP_SHIFT +: 17];
    end

    // Stage 3: remainder
    always_comb
    begin
        s4_next    = s3_reg;
        s4_next.dr = 10'(s3_reg.delta - 26'(s3_reg.dq) * 26'(MS_PER_SEC));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= in_data;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_work  = s4_reg;

endmodule

// ----- design/sfs_state.sv -----
module sfs_state import sfs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  sfs_cfg_t  cfg,
    input  logic      cfg_clear,
    input  logic      in_valid,
    output logic      in_ready,
    input  sfs_work_t in_work,
    output logic      res_valid,
    input  logic      res_stall,
    output sfs_out_t  res_data
);

    logic [31:0] p_reg, p_next;       // acc * rate, wrapped
    logic [22:0] q_reg, q_next;       // p / 1000, the current slot
    logic [9:0]  r_reg, r_next;       // p % 1000
    logic [7:0]  frame_reg, frame_next;
    logic        halted_reg, halted_next;
    logic        res_valid_reg, res_valid_next;
    sfs_out_t    res_data_reg, res_data_next;

    logic        take, fire, done;
    logic [8:0]  count;
    logic [7:0]  last_frame, adv_frame, prev_frame, goto_frame;
    logic        adv_wrap;
    logic [32:0] p_sum;
    logic        wrap;
    logic [11:0] r_sum;
    logic        r_neg, r_over;
    logic [9:0]  r_new;
    logic [22:0] q_new;

    assign take     = !res_valid_reg || !res_stall;
    assign fire     = in_valid && take;
    assign in_ready = take;

    always_comb
    begin
        count = (cfg.frame_count == 9'd0) ? 9'd1 : cfg.frame_count;
        if (count > FRAME_LIMIT)
        begin
            count = FRAME_LIMIT;
        end
    end

    assign last_frame = 8'(count - 9'd1);
    assign adv_wrap   = ({1'b0, frame_reg} + 9'd1) >= count;
    assign adv_frame  = adv_wrap ? 8'd0 : frame_reg + 8'd1;
    assign prev_frame = (frame_reg == 8'd0 || ({1'b0, frame_reg} - 9'd1) >= count)
                        ? last_frame : frame_reg - 8'd1;
    assign goto_frame = ({1'b0, in_work.target_frame} >= count)
                        ? last_frame : in_work.target_frame;

    // Advance the quotient/remainder pair; take out 2^32 on wrap
    assign p_sum  = {1'b0, p_reg} + 33'(in_work.delta);
    assign wrap   = p_sum[32];
    assign r_sum  = 12'(r_reg) + 12'(in_work.dr) - (wrap ? WRAP_R : 12'd0);
    assign r_neg  = r_sum[11];
    assign r_over = !r_neg && (r_sum >= 12'(MS_PER_SEC));
    assign r_new  = r_neg  ? 10'(r_sum + 12'(MS_PER_SEC)) :
                    r_over ? 10'(r_sum - 12'(MS_PER_SEC)) : r_sum[9:0];
    assign q_new  = q_reg + 23'(in_work.dq) + (r_over ? 23'd1 : 23'd0)
                    - (r_neg ? 23'd1 : 23'd0) - (wrap ? WRAP_Q : 23'd0);

    always_comb
    begin
        p_next      = p_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        frame_next  = frame_reg;
        halted_next = halted_reg;
        done        = 1'b0;
        case (in_work.req_type)
            REQ_TICK:
            begin
                if (!halted_reg && cfg.clip_loaded)
                begin
                    p_next = p_sum[31:0];
                    q_next = q_new;
                    r_next = r_new;
                    if (q_new != q_reg)
                    begin
                        frame_next = adv_frame;
                        done       = adv_wrap;
                    end
                end
            end
            REQ_PLAY:      halted_next = 1'b0;
            REQ_STOP:      halted_next = 1'b1;
            REQ_GOTO_PLAY:
            begin
                frame_next  = goto_frame;
                halted_next = 1'b0;
            end
            REQ_GOTO_STOP:
            begin
                frame_next  = goto_frame;
                halted_next = 1'b1;
            end
            REQ_NEXT:      frame_next = adv_frame;
            REQ_PREV:      frame_next = prev_frame;
            default:       ;
        endcase
    end

    always_comb
    begin
        res_data_next.current_frame = frame_next;
        res_data_next.playing       = !halted_next;
        res_data_next.cycle_done    = done;
        res_valid_next              = take ? in_valid : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg         <= '0;
            q_reg         <= '0;
            r_reg         <= '0;
            frame_reg     <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_clear)
            begin
                p_reg <= '0;
                q_reg <= '0;
                r_reg <= '0;
            end
            else if (fire)
            begin
                p_reg      <= p_next;
                q_reg      <= q_next;
                r_reg      <= r_next;
                frame_reg  <= frame_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_reg < 10'(MS_PER_SEC))
        else $error("remainder out of range");

    a_slot_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg == 32'(q_reg) * 32'(MS_PER_SEC) + 32'(r_reg))
        else $error("slot does not match scaled time");

    a_done_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.cycle_done |->
            res_data_reg.current_frame == 8'd0 && res_data_reg.playing)
        else $error("cycle_done without wrap to frame zero while playing");

    a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_stall |=> $stable(frame_reg) && $stable(halted_reg))
        else $error("state moved while result stalled");

endmodule

// ----- design/sprite_frame_sequencer_core.sv -----
// Sprite frame sequencer.
// Requests come in on the req channel (req_valid/req_stall/req_data), one
// transfer per request: tick with elapsed milliseconds, play, stop, goto
// and play, goto and stop, next frame, previous frame. Every request gives
// exactly one transfer on the res channel: current frame, playing flag and
// cycle_done (set only when a tick wrapped the last frame to frame zero).
// One request per cycle is sustained while res_stall is low. Three stages
// precompute the time step per tick (ms * rate, then quotient and
// remainder by 1000); the fourth updates the frame state and loads the
// result register. With res_stall high the result holds and up to five
// requests stay in flight; req_stall then rises until the receiver takes
// the result. Reset leaves the block playing at frame 0 with
// frame_count 1, frame_rate 1 and no clip loaded. The APB port writes
// frame_count (0x0), frame_rate (0x4) and clip_loaded (0x8); the user
// must write them only while the block is idle, which the block does not
// enforce. Any such write clears the time accumulator and the slot.
module sprite_frame_sequencer_core import sfs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  sfs_in_t     req_data,
    output logic        res_valid,
    input  logic        res_stall,
    output sfs_out_t    res_data
);

    sfs_cfg_t   cfg_reg, cfg_next;
    logic       cfg_wr, cfg_clear;
    logic [1:0] reg_idx;

    logic       in_ready;
    logic       work_valid, work_ready;
    sfs_work_t  work;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Decode the write; an address beyond the last register is dropped
    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_clear = 1'b0;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_FRAME_COUNT:
                begin
                    cfg_next.frame_count = pwdata[8:0];
                    cfg_clear            = 1'b1;
                end
                REG_FRAME_RATE:
                begin
                    cfg_next.frame_rate = pwdata[9:0];
                    cfg_clear           = 1'b1;
                end
                REG_CLIP_LOADED:
                begin
                    cfg_next.clip_loaded = pwdata[0];
                    cfg_clear            = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count <= 9'd1;
            cfg_reg.frame_rate  <= 10'd1;
            cfg_reg.clip_loaded <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        case (reg_idx)
            REG_FRAME_COUNT: prdata = 32'(cfg_reg.frame_count);
            REG_FRAME_RATE:  prdata = 32'(cfg_reg.frame_rate);
            REG_CLIP_LOADED: prdata = 32'(cfg_reg.clip_loaded);
            default:         prdata = 32'd0;
        endcase
    end

    assign req_stall = !in_ready;

    sfs_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (req_valid),
        .in_ready  (in_ready),
        .in_data   (req_data),
        .out_valid (work_valid),
        .out_ready (work_ready),
        .out_work  (work)
    );

    sfs_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .in_valid  (work_valid),
        .in_ready  (work_ready),
        .in_work   (work),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
